[sv/i2cm_pkg.sv]
// shared types, codes and defaults for the i2c master byte engine
package i2cm_pkg;

  localparam int unsigned TickWidthDef    = 16;
  localparam int unsigned CfgWidth        = 16;
  localparam logic [15:0] HalfBitTicksRst = 16'd100;
  localparam logic [7:0]  AckWaitLimitRst = 8'd250;
  localparam logic [7:0]  ReadBitMsb      = 8'h80;

  typedef enum logic [0:0] {
    CFG_HALF_BIT_TICKS = 1'b0,
    CFG_ACK_WAIT_LIMIT = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    CMD_NONE      = 3'd0,
    CMD_START     = 3'd1,
    CMD_STOP      = 3'd2,
    CMD_WRITE_ACK = 3'd3,
    CMD_READ_ACK  = 3'd4,
    CMD_WRITE     = 3'd5,
    CMD_READ      = 3'd6
  } cmd_e;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_COND_A   = 4'd1,
    PH_COND_B   = 4'd2,
    PH_COND_C   = 4'd3,
    PH_BIT_HI   = 4'd4,
    PH_BIT_LO   = 4'd5,
    PH_ACK_HI   = 4'd6,
    PH_ACK_WAIT = 4'd7,
    PH_K_PRE    = 4'd8,
    PH_K_SET    = 4'd9,
    PH_K_HI     = 4'd10,
    PH_TAIL_LO  = 4'd11
  } phase_e;

  typedef struct packed {
    phase_e      phase;
    logic [3:0]  bit_idx;
    logic [7:0]  shift;
    logic [7:0]  wait_cnt;
    cmd_e        pending;
    logic        ack_choice;
    logic        scl;
    logic        sda;
    logic        sda_en;
    logic        err;
    logic [7:0]  rx_last;
  } i2cm_state_t;

  typedef struct packed {
    logic        scl_out;
    logic        sda_out;
    logic        sda_drive;
    logic        busy;
    logic        done;
    logic [7:0]  rx_byte;
    logic        ack_error;
  } i2cm_res_t;

endpackage

[sv/i2cm_step.sv]
// one-tick next-state and result logic of the i2c line sequencer
module i2cm_step import i2cm_pkg::*; #(
  parameter int unsigned TICK_WIDTH = TickWidthDef
) (
  input  i2cm_state_t           state_i,
  input  logic [TICK_WIDTH-1:0] hold_i,
  input  logic [TICK_WIDTH-1:0] half_i,
  input  logic [7:0]            limit_i,
  input  logic [2:0]            action_i,
  input  logic [7:0]            tx_byte_i,
  input  logic                  send_ack_i,
  input  logic                  sda_in_i,
  output i2cm_state_t           state_o,
  output logic [TICK_WIDTH-1:0] hold_o,
  output i2cm_res_t             res_o
);

  function automatic i2cm_state_t enter_f(i2cm_state_t st, phase_e ph,
                                          logic scl, logic sda, logic en);
    i2cm_state_t r;
    r        = st;
    r.phase  = ph;
    r.scl    = scl;
    r.sda    = sda;
    r.sda_en = en;
    return r;
  endfunction

  function automatic logic is_read_f(cmd_e c);
    return (c == CMD_READ_ACK) || (c == CMD_READ);
  endfunction

  function automatic i2cm_state_t enter_bit_f(i2cm_state_t st);
    i2cm_state_t r;
    if (is_read_f(st.pending)) begin
      r = enter_f(st, PH_BIT_HI, 1'b1, st.sda, 1'b0);
    end else begin
      r = enter_f(st, PH_BIT_HI, 1'b1, st.shift[3'd7 - st.bit_idx[2:0]], 1'b1);
    end
    return r;
  endfunction

  i2cm_state_t           s;
  logic [TICK_WIDTH-1:0] hc;
  logic [TICK_WIDTH-1:0] hload;
  logic                  done;
  logic                  do_ack;

  assign hload = (half_i == '0) ? '0 : (half_i - TICK_WIDTH'(1));

  always_comb begin
    s      = state_i;
    hc     = hold_i;
    done   = 1'b0;
    do_ack = 1'b0;

    if (s.phase != PH_IDLE) begin
      if (s.phase == PH_ACK_WAIT) begin
        do_ack = 1'b1;
      end else if (hc != '0) begin
        hc = hc - TICK_WIDTH'(1);
      end else begin
        case (s.phase)
          PH_COND_A: begin
            s  = enter_f(s, PH_COND_B, 1'b1, (s.pending == CMD_START) ? 1'b0 : 1'b1, 1'b1);
            hc = hload;
          end
          PH_COND_B: begin
            s  = enter_f(s, PH_COND_C, 1'b0, s.sda, 1'b1);
            hc = hload;
          end
          PH_BIT_HI: begin
            if (is_read_f(s.pending) && sda_in_i) begin
              s.shift = s.shift | (ReadBitMsb >> s.bit_idx[2:0]);
            end
            s  = enter_f(s, PH_BIT_LO, 1'b0, s.sda, s.sda_en);
            hc = hload;
          end
          PH_BIT_LO: begin
            s.bit_idx = s.bit_idx + 4'd1;
            if (s.bit_idx < 4'd8) begin
              s  = enter_bit_f(s);
              hc = hload;
            end else if (s.pending == CMD_WRITE_ACK) begin
              s.wait_cnt = '0;
              s  = enter_f(s, PH_ACK_HI, 1'b1, s.sda, 1'b0);
              hc = hload;
            end else if (s.pending == CMD_READ_ACK) begin
              s.rx_last = s.shift;
              s  = enter_f(s, PH_K_PRE, 1'b0, s.sda, 1'b0);
              hc = hload;
            end else begin
              if (is_read_f(s.pending)) begin
                s.rx_last = s.shift;
              end
              s.phase = PH_IDLE;
              s.scl   = 1'b0;
              done    = 1'b1;
            end
          end
          PH_ACK_HI: begin
            s.phase = PH_ACK_WAIT;
            do_ack  = 1'b1;
          end
          PH_K_PRE: begin
            s  = enter_f(s, PH_K_SET, 1'b0, ~s.ack_choice, 1'b1);
            hc = hload;
          end
          PH_K_SET: begin
            s  = enter_f(s, PH_K_HI, 1'b1, s.sda, 1'b1);
            hc = hload;
          end
          PH_K_HI: begin
            s  = enter_f(s, PH_TAIL_LO, 1'b0, s.sda, s.sda_en);
            hc = hload;
          end
          default: begin
            s.phase = PH_IDLE;
            s.scl   = 1'b0;
            done    = 1'b1;
          end
        endcase
      end

      if (do_ack) begin
        if (!sda_in_i) begin
          s.err = 1'b0;
          s  = enter_f(s, PH_TAIL_LO, 1'b0, s.sda, 1'b0);
          hc = hload;
        end else if (s.wait_cnt >= limit_i) begin
          s.err   = 1'b1;
          s.phase = PH_IDLE;
          s.scl   = 1'b0;
          done    = 1'b1;
        end else begin
          s.wait_cnt = s.wait_cnt + 8'd1;
        end
      end
    end

    if (s.phase == PH_IDLE) begin
      case (action_i)
        CMD_START: begin
          s.pending = CMD_START;
          s.bit_idx = '0;
          s  = enter_f(s, PH_COND_A, 1'b1, 1'b1, 1'b1);
          hc = hload;
        end
        CMD_STOP: begin
          s.pending = CMD_STOP;
          s.bit_idx = '0;
          s  = enter_f(s, PH_COND_A, 1'b1, 1'b0, 1'b1);
          hc = hload;
        end
        CMD_WRITE_ACK, CMD_WRITE: begin
          s.pending = cmd_e'(action_i);
          s.bit_idx = '0;
          s.shift   = tx_byte_i;
          s  = enter_bit_f(s);
          hc = hload;
        end
        CMD_READ_ACK, CMD_READ: begin
          s.pending    = cmd_e'(action_i);
          s.bit_idx    = '0;
          s.shift      = '0;
          s.ack_choice = send_ack_i;
          s  = enter_bit_f(s);
          hc = hload;
        end
        default: begin
        end
      endcase
    end

    state_o         = s;
    hold_o          = hc;
    res_o.scl_out   = s.scl;
    res_o.sda_out   = s.sda;
    res_o.sda_drive = s.sda_en;
    res_o.busy      = (s.phase != PH_IDLE);
    res_o.done      = done;
    res_o.rx_byte   = s.rx_last;
    res_o.ack_error = s.err;
  end

endmodule

[sv/i2c_master_byte_engine_top.sv]
// top level: input register, sequencer state and result register
// path: a tick beat is captured in the input register, then moved into the state and the
//   result register together once the result register is free or being read out
// throughput: one tick per cycle while result beats are taken without a stall
// reset: asynchronous active low; line state idle with scl low, sda high and driven,
//   registers back to 100 ticks per phase and an ack-wait limit of 250
module i2c_master_byte_engine_top import i2cm_pkg::*; #(
  parameter int unsigned TICK_WIDTH = TickWidthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [CfgWidth-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [2:0]          action_i,
  input  logic [7:0]          tx_byte_i,
  input  logic                send_ack_i,
  input  logic                sda_in_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                scl_out_o,
  output logic                sda_out_o,
  output logic                sda_drive_o,
  output logic                busy_res_o,
  output logic                done_res_o,
  output logic [7:0]          rx_byte_o,
  output logic                ack_error_o
);

  localparam i2cm_state_t StateRst = '{
    phase: PH_IDLE, bit_idx: '0, shift: '0, wait_cnt: '0, pending: CMD_NONE,
    ack_choice: 1'b0, scl: 1'b0, sda: 1'b1, sda_en: 1'b1, err: 1'b0, rx_last: '0
  };

  logic [TICK_WIDTH-1:0] half_q;
  logic [7:0]            limit_q;

  logic                  in_vld_q;
  logic [2:0]            action_q;
  logic [7:0]            tx_byte_q;
  logic                  send_ack_q;
  logic                  sda_in_q;

  i2cm_state_t           state_q, state_d;
  logic [TICK_WIDTH-1:0] hold_q, hold_d;
  logic                  out_vld_q;
  i2cm_res_t             res_q, res_d;
  logic                  step;

  assign step       = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q  <= TICK_WIDTH'(HalfBitTicksRst);
      limit_q <= AckWaitLimitRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_HALF_BIT_TICKS: half_q  <= TICK_WIDTH'(cfg_wdata_i);
        CFG_ACK_WAIT_LIMIT: limit_q <= cfg_wdata_i[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      action_q   <= action_i;
      tx_byte_q  <= tx_byte_i;
      send_ack_q <= send_ack_i;
      sda_in_q   <= sda_in_i;
    end
  end

  i2cm_step #(
    .TICK_WIDTH (TICK_WIDTH)
  ) u_step (
    .state_i    (state_q),
    .hold_i     (hold_q),
    .half_i     (half_q),
    .limit_i    (limit_q),
    .action_i   (action_q),
    .tx_byte_i  (tx_byte_q),
    .send_ack_i (send_ack_q),
    .sda_in_i   (sda_in_q),
    .state_o    (state_d),
    .hold_o     (hold_d),
    .res_o      (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StateRst;
      hold_q    <= '0;
      out_vld_q <= 1'b0;
    end else if (step) begin
      state_q   <= state_d;
      hold_q    <= hold_d;
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign scl_out_o   = res_q.scl_out;
  assign sda_out_o   = res_q.sda_out;
  assign sda_drive_o = res_q.sda_drive;
  assign busy_res_o  = res_q.busy;
  assign done_res_o  = res_q.done;
  assign rx_byte_o   = res_q.rx_byte;
  assign ack_error_o = res_q.ack_error;

endmodule

[sv/i2cm_checker.sv]
// port-level assertions for the i2c master byte engine, bound to the top level
module i2cm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic [2:0] action_i,
  input logic [7:0] tx_byte_i,
  input logic       send_ack_i,
  input logic       sda_in_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       scl_out_o,
  input logic       sda_out_o,
  input logic       sda_drive_o,
  input logic       busy_res_o,
  input logic       done_res_o,
  input logic [7:0] rx_byte_o,
  input logic       ack_error_o
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(scl_out_o)
      && $stable(sda_out_o) && $stable(sda_drive_o) && $stable(busy_res_o)
      && $stable(done_res_o) && $stable(rx_byte_o) && $stable(ack_error_o))
    else $error("result beat changed while stalled");

  // idle bus leaves scl low
  a_idle_scl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !busy_res_o |-> !scl_out_o)
    else $error("scl high while idle");

  // empty result register never blocks input
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

  // waiting input beat holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(action_i)
      && $stable(tx_byte_i) && $stable(send_ack_i) && $stable(sda_in_i))
    else $error("input beat changed while waiting");

endmodule

bind i2c_master_byte_engine_top i2cm_checker u_i2cm_checker (.*);

[tb/i2c_master_byte_engine_top_tb.sv]
// self-checking testbench for the i2c master byte engine: line-level prediction per tick
`timescale 1ns / 1ps

module i2c_master_byte_engine_top_tb;
  import i2cm_pkg::*;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] tx;
    logic       ack;
    logic       sda;
  } tick_t;

  typedef struct packed {
    logic [15:0] half_ticks;
    logic [7:0]  wait_lim;
    phase_e      ph;
    logic [3:0]  bit_pos;
    logic [7:0]  shifter;
    logic [15:0] hold_left;
    logic [7:0]  ack_waited;
    cmd_e        cmd;
    logic        ack_sel;
    logic        scl;
    logic        sda;
    logic        sda_en;
    logic        nacked;
    logic [7:0]  rx_hold;
    logic        done;
  } line_state_t;

  typedef enum logic [1:0] {SLV_RANDOM, SLV_NACK, SLV_HIGH, SLV_LOW} slave_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [2:0]  action_i = '0;
  logic [7:0]  tx_byte_i = '0;
  logic        send_ack_i = 1'b0;
  logic        sda_in_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        scl_out_o;
  logic        sda_out_o;
  logic        sda_drive_o;
  logic        busy_res_o;
  logic        done_res_o;
  logic [7:0]  rx_byte_o;
  logic        ack_error_o;

  i2c_master_byte_engine_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .action_i    (action_i),
    .tx_byte_i   (tx_byte_i),
    .send_ack_i  (send_ack_i),
    .sda_in_i    (sda_in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .scl_out_o   (scl_out_o),
    .sda_out_o   (sda_out_o),
    .sda_drive_o (sda_drive_o),
    .busy_res_o  (busy_res_o),
    .done_res_o  (done_res_o),
    .rx_byte_o   (rx_byte_o),
    .ack_error_o (ack_error_o)
  );

  line_state_t model_st;
  line_state_t gen_st;
  tick_t       tick_q[$];
  i2cm_res_t   lines_due[$];
  tick_t       beat_now;
  i2cm_res_t   want_r;
  bit          gaps_on;
  bit          stalls_on;
  int unsigned send_gap;
  int unsigned stall_left;
  int unsigned ticks_sent;
  int unsigned results_seen;
  int unsigned cmds_issued;
  int unsigned settings_done;
  int unsigned flaws;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic line_state_t reset_state();
    line_state_t s;
    s = '0;
    s.half_ticks = HalfBitTicksRst;
    s.wait_lim   = AckWaitLimitRst;
    s.ph         = PH_IDLE;
    s.cmd        = CMD_NONE;
    s.sda        = 1'b1;
    s.sda_en     = 1'b1;
    return s;
  endfunction

  function automatic void hold_phase(inout line_state_t s, input phase_e p,
                                     input logic scl_v, input logic sda_v, input logic en_v);
    logic [15:0] h;
    h = (s.half_ticks == 16'd0) ? 16'd1 : s.half_ticks;
    s.ph        = p;
    s.scl       = scl_v;
    s.sda       = sda_v;
    s.sda_en    = en_v;
    s.hold_left = h - 16'd1;
  endfunction

  function automatic void end_command(inout line_state_t s);
    s.ph   = PH_IDLE;
    s.scl  = 1'b0;
    s.done = 1'b1;
  endfunction

  function automatic logic reading(input line_state_t s);
    return (s.cmd == CMD_READ_ACK) || (s.cmd == CMD_READ);
  endfunction

  function automatic void drive_bit(inout line_state_t s);
    if (reading(s)) begin
      hold_phase(s, PH_BIT_HI, 1'b1, s.sda, 1'b0);
    end else begin
      hold_phase(s, PH_BIT_HI, 1'b1, s.shifter[3'd7 - s.bit_pos[2:0]], 1'b1);
    end
  endfunction

  function automatic void sample_ack(inout line_state_t s, input logic sda_v);
    if (!sda_v) begin
      s.nacked = 1'b0;
      hold_phase(s, PH_TAIL_LO, 1'b0, s.sda, 1'b0);
    end else if (s.ack_waited >= s.wait_lim) begin
      s.nacked = 1'b1;
      end_command(s);
    end else begin
      s.ack_waited = s.ack_waited + 8'd1;
    end
  endfunction

  function automatic void phase_expired(inout line_state_t s, input logic sda_v);
    case (s.ph)
      PH_COND_A: hold_phase(s, PH_COND_B, 1'b1, (s.cmd == CMD_START) ? 1'b0 : 1'b1, 1'b1);
      PH_COND_B: hold_phase(s, PH_COND_C, 1'b0, s.sda, 1'b1);
      PH_BIT_HI: begin
        if (reading(s) && sda_v) s.shifter = s.shifter | (ReadBitMsb >> s.bit_pos[2:0]);
        hold_phase(s, PH_BIT_LO, 1'b0, s.sda, s.sda_en);
      end
      PH_BIT_LO: begin
        s.bit_pos = s.bit_pos + 4'd1;
        if (s.bit_pos < 4'd8) begin
          drive_bit(s);
        end else if (s.cmd == CMD_WRITE_ACK) begin
          s.ack_waited = 8'd0;
          hold_phase(s, PH_ACK_HI, 1'b1, s.sda, 1'b0);
        end else if (s.cmd == CMD_READ_ACK) begin
          s.rx_hold = s.shifter;
          hold_phase(s, PH_K_PRE, 1'b0, s.sda, 1'b0);
        end else begin
          if (reading(s)) s.rx_hold = s.shifter;
          end_command(s);
        end
      end
      PH_ACK_HI: begin
        s.ph = PH_ACK_WAIT;
        sample_ack(s, sda_v);
      end
      PH_K_PRE: hold_phase(s, PH_K_SET, 1'b0, !s.ack_sel, 1'b1);
      PH_K_SET: hold_phase(s, PH_K_HI, 1'b1, s.sda, 1'b1);
      PH_K_HI:  hold_phase(s, PH_TAIL_LO, 1'b0, s.sda, s.sda_en);
      default:  end_command(s);
    endcase
  endfunction

  // one timing tick: advance the line sequencer, then take a command if idle
  function automatic i2cm_res_t line_tick(inout line_state_t s, input tick_t t);
    i2cm_res_t r;
    s.done = 1'b0;
    if (s.ph != PH_IDLE) begin
      if (s.ph == PH_ACK_WAIT) begin
        sample_ack(s, t.sda);
      end else if (s.hold_left != 16'd0) begin
        s.hold_left = s.hold_left - 16'd1;
      end else begin
        phase_expired(s, t.sda);
      end
    end
    if (s.ph == PH_IDLE && t.action >= CMD_START && t.action <= CMD_READ) begin
      s.cmd     = cmd_e'(t.action);
      s.bit_pos = 4'd0;
      case (s.cmd)
        CMD_START: hold_phase(s, PH_COND_A, 1'b1, 1'b1, 1'b1);
        CMD_STOP:  hold_phase(s, PH_COND_A, 1'b1, 1'b0, 1'b1);
        CMD_WRITE_ACK, CMD_WRITE: begin
          s.shifter = t.tx;
          drive_bit(s);
        end
        default: begin
          s.shifter = 8'd0;
          s.ack_sel = t.ack;
          drive_bit(s);
        end
      endcase
    end
    r.scl_out   = s.scl;
    r.sda_out   = s.sda;
    r.sda_drive = s.sda_en;
    r.busy      = (s.ph != PH_IDLE);
    r.done      = s.done;
    r.rx_byte   = s.rx_hold;
    r.ack_error = s.nacked;
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // sender: one tick beat at a time from the pending queue
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      action_i   <= '0;
      tx_byte_i  <= '0;
      send_ack_i <= 1'b0;
      sda_in_i   <= 1'b0;
      send_gap   = 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        lines_due.push_back(line_tick(model_st, beat_now));
        ticks_sent++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (tick_q.size() != 0) begin
          beat_now = tick_q.pop_front();
          in_valid_i <= 1'b1;
          action_i   <= beat_now.action;
          tx_byte_i  <= beat_now.tx;
          send_ack_i <= beat_now.ack;
          sda_in_i   <= beat_now.sda;
          send_gap   = gaps_on ? pick_gap() : 0;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  task automatic note_flaw(input string what, input logic [7:0] want, input logic [7:0] got);
    if (flaws < 10) begin
      $display("mismatch on %s at result %0d: expected %0h, got %0h",
               what, results_seen, want, got);
    end
    flaws++;
  endtask

  task automatic check_field(input string what, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) note_flaw(what, want, got);
  endtask

  // receiver: compare each result beat with the oldest expected line state
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left  = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (lines_due.size() == 0) begin
          note_flaw("result with nothing due", 8'h00, 8'h00);
        end else begin
          want_r = lines_due.pop_front();
          check_field("scl_out", 8'(want_r.scl_out), 8'(scl_out_o));
          check_field("sda_out", 8'(want_r.sda_out), 8'(sda_out_o));
          check_field("sda_drive", 8'(want_r.sda_drive), 8'(sda_drive_o));
          check_field("busy", 8'(want_r.busy), 8'(busy_res_o));
          check_field("done", 8'(want_r.done), 8'(done_res_o));
          check_field("rx_byte", want_r.rx_byte, rx_byte_o);
          check_field("ack_error", 8'(want_r.ack_error), 8'(ack_error_o));
        end
        results_seen++;
      end
      if (stall_left != 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if (stalls_on && $urandom_range(0, 5) == 0) stall_left = pick_gap();
      end
    end
  end

  function automatic logic pick_sda(input slave_e slv);
    if (gen_st.ph == PH_ACK_HI || gen_st.ph == PH_ACK_WAIT) begin
      if (slv == SLV_LOW) return 1'b0;
      if (slv == SLV_RANDOM) return ($urandom_range(0, 2) == 0) ? 1'b0 : 1'b1;
      return 1'b1;
    end
    if (slv == SLV_HIGH) return 1'b1;
    if (slv == SLV_LOW) return 1'b0;
    return 1'($urandom);
  endfunction

  task automatic push_tick(input tick_t t);
    void'(line_tick(gen_st, t));
    tick_q.push_back(t);
  endtask

  // tick the bus until the command ends; with chain set, stop short of the
  // finishing tick so the next command lands on it
  task automatic settle(input slave_e slv, input bit chain);
    line_state_t probe;
    tick_t       t;
    while (gen_st.ph != PH_IDLE) begin
      t.action = CMD_NONE;
      t.tx     = 8'($urandom);
      t.ack    = 1'($urandom);
      t.sda    = pick_sda(slv);
      probe    = gen_st;
      void'(line_tick(probe, t));
      if (probe.ph == PH_IDLE && chain) break;
      if (probe.ph != PH_IDLE && $urandom_range(0, 9) == 0) t.action = 3'($urandom_range(1, 7));
      push_tick(t);
    end
    if (!chain) begin
      repeat ($urandom_range(0, 2)) begin
        t.action = ($urandom_range(0, 3) == 0) ? 3'd7 : CMD_NONE;
        t.tx     = 8'($urandom);
        t.ack    = 1'($urandom);
        t.sda    = 1'($urandom);
        push_tick(t);
      end
    end
  endtask

  task automatic run_command(input logic [2:0] act, input logic [7:0] tx, input logic ack,
                             input slave_e slv, input bit chain);
    tick_t t;
    t.action = act;
    t.tx     = tx;
    t.ack    = ack;
    t.sda    = pick_sda(slv);
    push_tick(t);
    if (act >= CMD_START && act <= CMD_READ) cmds_issued++;
    settle(slv, chain);
  endtask

  task automatic drain();
    do @(negedge clk_i); while (tick_q.size() != 0 || in_valid_i || lines_due.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic apply_setting(input logic [15:0] half, input logic [7:0] lim);
    settle(SLV_RANDOM, 1'b0);
    drain();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_HALF_BIT_TICKS;
    cfg_wdata_i <= half;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_ACK_WAIT_LIMIT;
    cfg_wdata_i <= {8'h00, lim};
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    model_st.half_ticks = half;
    model_st.wait_lim   = lim;
    gen_st.half_ticks   = half;
    gen_st.wait_lim     = lim;
    settings_done++;
  endtask

  task automatic bus_transfer();
    logic [2:0] act;
    if ($urandom_range(0, 99) < 85) begin
      run_command(CMD_START, 8'($urandom), 1'($urandom), SLV_RANDOM, 1'($urandom));
      run_command(CMD_WRITE_ACK, 8'($urandom), 1'($urandom),
                  ($urandom_range(0, 4) == 0) ? SLV_NACK : SLV_RANDOM, 1'($urandom));
      repeat ($urandom_range(1, 2)) begin
        act = 3'(CMD_WRITE_ACK) + 3'($urandom_range(0, 3));
        run_command(act, 8'($urandom), 1'($urandom), slave_e'($urandom_range(0, 3)),
                    1'($urandom));
      end
      run_command(CMD_STOP, 8'($urandom), 1'($urandom), SLV_RANDOM, 1'($urandom));
    end else begin
      repeat ($urandom_range(1, 6)) begin
        run_command(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom),
                    slave_e'($urandom_range(0, 3)), 1'($urandom));
      end
    end
  endtask

  initial begin
    tick_t       t;
    int unsigned start_cmds;
    int unsigned quota;
    logic [15:0] half;
    logic [7:0]  lim;
    model_st  = reset_state();
    gen_st    = reset_state();
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // out of reset: a plain tick, then the unused action code with every field high
    t = '0;
    push_tick(t);
    t = '1;
    push_tick(t);

    apply_setting(16'd1, 8'd2);
    run_command(CMD_START, 8'h00, 1'b0, SLV_RANDOM, 1'b0);
    run_command(CMD_WRITE_ACK, 8'hFF, 1'b0, SLV_LOW, 1'b0);
    run_command(CMD_WRITE_ACK, 8'h00, 1'b1, SLV_NACK, 1'b0);
    run_command(CMD_WRITE, 8'hA5, 1'b0, SLV_NACK, 1'b1);
    run_command(CMD_READ_ACK, 8'h00, 1'b1, SLV_HIGH, 1'b0);
    run_command(CMD_READ_ACK, 8'hFF, 1'b0, SLV_LOW, 1'b0);
    run_command(CMD_READ, 8'h5A, 1'b1, SLV_RANDOM, 1'b1);
    run_command(CMD_WRITE_ACK, 8'h3C, 1'b0, SLV_RANDOM, 1'b1);
    run_command(CMD_STOP, 8'h00, 1'b0, SLV_RANDOM, 1'b0);
    // a command issued while busy must be dropped
    t = '0;
    t.action = CMD_START;
    push_tick(t);
    t.action = CMD_STOP;
    push_tick(t);
    settle(SLV_RANDOM, 1'b0);

    // slow phase setting, one start condition
    apply_setting(16'd12, 8'hFF);
    run_command(CMD_START, 8'h00, 1'b0, SLV_RANDOM, 1'b0);

    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin half = 16'd1; lim = 8'd0;   gaps_on = 1'b1; stalls_on = 1'b1; quota = 1; end
        1: begin half = 16'd2; lim = 8'd3;   gaps_on = 1'b0; stalls_on = 1'b0; quota = 1; end
        2: begin half = 16'd0; lim = 8'd255; gaps_on = 1'b1; stalls_on = 1'b0; quota = 1; end
        3: begin
          half = 16'($urandom_range(1, 2));
          lim  = 8'($urandom_range(0, 8));
          gaps_on = 1'b0; stalls_on = 1'b1; quota = 1;
        end
        default: begin
          half = 16'd1; lim = 8'd1;
          gaps_on = 1'b1; stalls_on = 1'b1; quota = 1;
        end
      endcase
      apply_setting(half, lim);
      start_cmds = cmds_issued;
      while (cmds_issued - start_cmds < quota) bus_transfer();
    end

    settle(SLV_RANDOM, 1'b0);
    drain();
    repeat (20) @(posedge clk_i);
    if (lines_due.size() != 0) flaws += lines_due.size();
    $display("covered %0d bus commands over %0d line ticks in %0d register settings",
             cmds_issued, ticks_sent, settings_done);
    $display("%0d result beats checked, %0d mismatches", results_seen, flaws);
    if (flaws == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #50000000;
    $display("timeout with %0d results still due", lines_due.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

[filelist.f]
sv/i2cm_pkg.sv
sv/i2cm_step.sv
sv/i2c_master_byte_engine_top.sv
sv/i2cm_checker.sv
tb/i2c_master_byte_engine_top_tb.sv
